[hdl/aavd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavd_pkg: shared constants and types for the averaging voltmeter
// Widths of the item fields and the fixed-point constants for the block
// average, the volts scaling and the split into decimal digits.
// ----------------------------------------------------------------------------
package aavd_pkg;

	// Samples per block minus one, and digits on the display.
	localparam int BLOCK_LIMIT    = 10;
	localparam int DISPLAY_DIGITS = 6;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 16;
	localparam int CNT_W    = 4;
	localparam int UNITS_W  = 3;
	localparam int DIGIT_W  = 4;

	function automatic longint pow10(input int n);
		longint r;
		r = 1;
		for (int i = 0; i < n; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

	// Block average: floor(sum / BLOCK_N) as (sum * AVG_RECIP) >> AVG_SHIFT,
	// exact for every SUM_W-bit sum.
	localparam int     BLOCK_N    = BLOCK_LIMIT + 1;
	localparam int     AVG_SHIFT  = SUM_W + $clog2(BLOCK_N);
	localparam longint AVG_RECIP  = ((longint'(1) << AVG_SHIFT) + BLOCK_N - 1) / BLOCK_N;
	localparam int     RECIP_W    = SUM_W + 1;
	localparam int     AVG_PROD_W = SUM_W + RECIP_W;

	// Volts in units of 10 uV: floor(avg * SCALE_MUL / 4096) * SCALE_PAD.
	localparam int     SCALE_DIGITS = (DISPLAY_DIGITS < 6) ? DISPLAY_DIGITS : 6;
	localparam longint SCALE_MUL    = 5 * pow10(SCALE_DIGITS - 1);
	localparam longint SCALE_PAD    = pow10(6 - SCALE_DIGITS);
	localparam int     SCALE_W      = 19;
	localparam int     PAD_W        = 14;
	localparam int     SCALE_SHIFT  = SAMPLE_W;
	localparam int     SPROD_W      = SAMPLE_W + SCALE_W;
	localparam int     V5_W         = 19;

	// Split at the thousands: hi = v5 / 1000 by reciprocal, lo = remainder.
	localparam longint DIV_K      = 1000;
	localparam int     HI_W       = 9;
	localparam int     LO_W       = 10;
	localparam int     HI_SHIFT   = V5_W + LO_W;
	localparam longint HI_RECIP   = ((longint'(1) << HI_SHIFT) + DIV_K - 1) / DIV_K;
	localparam int     HI_RECIP_W = 20;
	localparam int     HPROD_W    = V5_W + HI_RECIP_W;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 40;

	typedef logic [DIGIT_W-1:0] digit_t;

	typedef struct packed {
		digit_t hundreds;
		digit_t tens;
		digit_t ones;
	} bcd3_t;

endpackage

[hdl/aavd_bin2bcd.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavd_bin2bcd: three-digit binary to decimal converter
// Shift-and-add-3 conversion of a value below 1000 into three decimal digits.
// ----------------------------------------------------------------------------
module aavd_bin2bcd
	import aavd_pkg::*;
(
	input  logic [LO_W-1:0] bin,
	output bcd3_t           bcd
);

	always_comb begin
		logic [3*DIGIT_W-1:0] acc;
		acc = '0;
		for (int i = LO_W - 1; i >= 0; i--) begin
			// adjust each digit that would pass nine on the next shift
			for (int d = 0; d < 3; d++) begin
				if (acc[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
					acc[d*DIGIT_W +: DIGIT_W] = acc[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
				end
			end
			acc = {acc[3*DIGIT_W-2:0], bin[i]};
		end
		bcd = acc;
	end

endmodule

[hdl/adc_average_volt_to_decimal_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_average_volt_to_decimal_core: block-averaging voltmeter with decimal out
// Sums converter samples over a block, takes the truncated mean, scales it to
// volts against a 5 V reference and gives the reading as six decimal digits.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Fields in tdata (lowest bit first)
// -------  ---  ----------------------------------------------------------------
// s_*      in   sample[11:0], zero pad [15:12]
// m_*      out  average_code[11:0], volts_units[14:12], tenths[18:15],
//               hundredths[22:19], thousandths[26:23], ten_thousandths[30:27],
//               hundred_thousandths[34:31], zero pad [39:35]
//
// One item is taken per cycle while s_tready is high. A block closes on its last
// sample and its result passes through stages s1 to s7 into the output
// register; samples that do not close a block give no result.
// The pipeline advances as a whole whenever the output register is empty or
// being taken, so a stalled result holds every stage and s_tready.
// Reset clears the running sum, the sample count and all stage valid bits.
// ----------------------------------------------------------------------------
module adc_average_volt_to_decimal_core
	import aavd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // sample[11:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // average_code, volts_units, 5 digits
);

	// Pipeline advance: the output register is empty or is being taken.
	logic adv;
	logic s_accept;

	// Open block state.
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   total;
	logic [CNT_W:0]     cnt_inc;
	logic               close_blk;

	// Stage valid bits.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic out_vld_q;

	// Stage payloads.
	logic [SUM_W-1:0]      tot_s1;
	logic [AVG_PROD_W-1:0] prod_s2;
	logic [SAMPLE_W-1:0]   avg_s3, avg_s4, avg_s5, avg_s6, avg_s7;
	logic [SPROD_W-1:0]    sprod_s4;
	logic [V5_W-1:0]       v5_s5, v5_s6;
	logic [HPROD_W-1:0]    hprod_s6;
	logic [HI_W-1:0]       hi_s7;
	logic [LO_W-1:0]       lo_s7;

	// Comb helpers.
	logic [SPROD_W-1:0]    scaled;
	logic [V5_W+PAD_W-1:0] padded;
	logic [HI_W-1:0]       hi;
	logic [V5_W-1:0]       hi_k;
	logic [LO_W-1:0]       lo;
	bcd3_t                 hi_bcd, lo_bcd;

	// Output register fields.
	logic [SAMPLE_W-1:0] avg_q;
	logic [UNITS_W-1:0]  units_q;
	digit_t              tenths_q, hundredths_q, thousandths_q;
	digit_t              ten_thou_q, hund_thou_q;

	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv;
	assign s_accept = s_tvalid && adv;

	// Accumulate: the count is one bit wider so the largest limit still closes.
	assign total     = sum_q + SUM_W'(s_tdata[SAMPLE_W-1:0]);
	assign cnt_inc   = {1'b0, count_q} + (CNT_W+1)'(1);
	assign close_blk = cnt_inc > (CNT_W+1)'(BLOCK_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			count_q   <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s_accept) begin
				if (close_blk) begin
					// close the block: clear for the next one
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= total;
					count_q <= cnt_inc[CNT_W-1:0];
				end
			end
			if (adv) begin
				vld_s1    <= s_accept && close_blk;
				vld_s2    <= vld_s1;
				vld_s3    <= vld_s2;
				vld_s4    <= vld_s3;
				vld_s5    <= vld_s4;
				vld_s6    <= vld_s5;
				vld_s7    <= vld_s6;
				out_vld_q <= vld_s7;
			end
		end
	end

	// Volts scaling and thousands split.
	assign scaled = sprod_s4 >> SCALE_SHIFT;
	assign padded = (V5_W+PAD_W)'(scaled[V5_W-1:0]) * (V5_W+PAD_W)'(SCALE_PAD);
	assign hi     = hprod_s6[HI_SHIFT +: HI_W];
	assign hi_k   = V5_W'(hi) * V5_W'(DIV_K);
	assign lo     = LO_W'(v5_s6 - hi_k);

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: closing sum of the block
			tot_s1   <= total;
			// s2: sum times reciprocal of the block size
			prod_s2  <= AVG_PROD_W'(tot_s1) * AVG_PROD_W'(AVG_RECIP);
			// s3: truncated mean
			avg_s3   <= prod_s2[AVG_SHIFT +: SAMPLE_W];
			// s4: mean times the volts scale
			sprod_s4 <= SPROD_W'(avg_s3) * SPROD_W'(SCALE_MUL);
			avg_s4   <= avg_s3;
			// s5: reading in units of 10 uV
			v5_s5    <= padded[V5_W-1:0];
			avg_s5   <= avg_s4;
			// s6: reading times reciprocal of 1000
			hprod_s6 <= HPROD_W'(v5_s5) * HPROD_W'(HI_RECIP);
			v5_s6    <= v5_s5;
			avg_s6   <= avg_s5;
			// s7: upper and lower three digits in binary
			hi_s7    <= hi;
			lo_s7    <= lo;
			avg_s7   <= avg_s6;
			// output: decimal digits
			avg_q         <= avg_s7;
			units_q       <= hi_bcd.hundreds[UNITS_W-1:0];
			tenths_q      <= hi_bcd.tens;
			hundredths_q  <= hi_bcd.ones;
			thousandths_q <= lo_bcd.hundreds;
			ten_thou_q    <= lo_bcd.tens;
			hund_thou_q   <= lo_bcd.ones;
		end
	end

	aavd_bin2bcd u_hi_bcd (
		.bin (LO_W'(hi_s7)),
		.bcd (hi_bcd)
	);

	aavd_bin2bcd u_lo_bcd (
		.bin (lo_s7),
		.bcd (lo_bcd)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {(OUT_DATA_W-SAMPLE_W-UNITS_W-5*DIGIT_W)'(0),
		hund_thou_q, ten_thou_q, thousandths_q, hundredths_q, tenths_q,
		units_q, avg_q};

endmodule
